// File: src/dvfs_pkg.sv
// Shared types and constants for the spherical-to-Cartesian direction vector block.
// Holds the Q60 CORDIC constants (built at elaboration) and the rotation step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvfs_pkg;

    localparam int Q60_W  = 64;
    localparam int Q60_FB = 60;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_CLOCKWISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLAR_FROM_AXIS   = 2'd1;

    typedef struct packed {
        logic azimuth_clockwise;
        logic polar_from_axis;
    } t_mode;

    // One CORDIC rotator: vector, residual angle, and the half-turn fold flag.
    typedef struct packed {
        logic signed [Q60_W-1:0] x;
        logic signed [Q60_W-1:0] y;
        logic signed [Q60_W-1:0] z;
        logic                    flip;
    } t_rot;

    // Restoring shift-and-subtract division; only used while the constants are built.
    function automatic logic [Q60_W-1:0] udiv64(input logic [Q60_W-1:0] num,
                                                input logic [Q60_W-1:0] den);
        logic [Q60_W:0]   rem;
        logic [Q60_W-1:0] quo;
        rem = '0;
        quo = '0;
        for (int b = Q60_W - 1; b >= 0; b--) begin
            rem = {rem[Q60_W-1:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Decimal digits packed as BCD, least significant digit converted first,
    // truncated to Q60.
    function automatic logic [Q60_W-1:0] q60_from_digits(input logic [75:0] bcd);
        logic [Q60_W-1:0] r;
        logic [Q60_W-1:0] d;
        r = '0;
        for (int n = 0; n < 19; n++) begin
            d = Q60_W'(bcd[4*n +: 4]);
            r = udiv64(r + (d << Q60_FB), 64'd10);
        end
        return r;
    endfunction

    localparam logic signed [Q60_W-1:0] QUARTER_PI_Q60 =
        signed'(q60_from_digits(76'h7853981633974483096));
    localparam logic signed [Q60_W-1:0] HALF_PI_Q60 = QUARTER_PI_Q60 <<< 1;
    localparam logic signed [Q60_W-1:0] PI_Q60      = QUARTER_PI_Q60 <<< 2;
    localparam logic signed [Q60_W-1:0] CORDIC_GAIN_Q60 =
        signed'(q60_from_digits(76'h6072529350088812561));

    // atan(2^-idx) in Q60 from the truncated Taylor series.
    function automatic logic [Q60_W-1:0] atan_q60(input int unsigned idx);
        logic [Q60_W-1:0] p;
        logic [Q60_W-1:0] sum;
        logic [Q60_W-1:0] term;
        logic [Q60_W-1:0] k;
        int unsigned      n;
        sum = '0;
        k   = '0;
        p   = (idx < 60) ? (64'd1 << (60 - idx)) : '0;
        for (n = 0; n < 64; n++) begin
            if (p != '0) begin
                term = udiv64(p, 64'd2 * k + 64'd1);
                sum  = k[0] ? (sum - term) : (sum + term);
                k    = k + 64'd1;
                p    = (2 * idx < 64) ? (p >> (2 * idx)) : '0;
            end
        end
        return (idx == 0) ? QUARTER_PI_Q60 : sum;
    endfunction

    // One rotation-mode step with floor shifts.
    function automatic t_rot cordic_step(input t_rot a, input int unsigned sh,
                                         input logic signed [Q60_W-1:0] ang);
        t_rot                    r;
        logic signed [Q60_W-1:0] dx;
        logic signed [Q60_W-1:0] dy;
        dx = $signed(a.y) >>> sh;
        dy = $signed(a.x) >>> sh;
        r  = a;
        if (!a.z[Q60_W-1]) begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - ang;
        end else begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + ang;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/direction_vector_from_spherical.sv
// From the start transfer to o_done the data passes the angle prep stages, the CORDIC stages
// (16 by default), the round stages and then the combine stages.
// Throughput: one angle pair per cycle; busy is high only in reset and the first cycle after it.
// Each result is held on o_vec_* for the single cycle that o_done is high; there is no stall.
// Synchronous active-low reset clears the pipeline valid bits and both mode registers and sets busy.
// Uses dvfs_pkg, dvfs_prep, dvfs_cordic_stage, dvfs_round and dvfs_combine.
`timescale 1ns / 1ps
`default_nettype none

module direction_vector_from_spherical
    import dvfs_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [FRAC_BITS+2:0]   i_azimuth_angle,
    input  wire logic signed [FRAC_BITS+2:0]   i_polar_angle,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic                               o_done,
    output logic signed [FRAC_BITS+1:0]        o_vec_x,
    output logic signed [FRAC_BITS+1:0]        o_vec_y,
    output logic signed [FRAC_BITS+1:0]        o_vec_z
);

    localparam int OUT_W = FRAC_BITS + 2;

    logic  r_busy;
    t_mode r_mode;

    logic  w_valid [CORDIC_STAGES+1];
    t_rot  w_az    [CORDIC_STAGES+1];
    t_rot  w_pol   [CORDIC_STAGES+1];

    logic                    w_rnd_valid;
    logic signed [OUT_W-1:0] w_cos_az;
    logic signed [OUT_W-1:0] w_sin_az;
    logic signed [OUT_W-1:0] w_cos_pol;
    logic signed [OUT_W-1:0] w_sin_pol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_mode <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AZIMUTH_CLOCKWISE: r_mode.azimuth_clockwise <= i_cfg_data[0];
                    CFG_POLAR_FROM_AXIS:   r_mode.polar_from_axis   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    dvfs_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !r_busy),
        .i_azimuth_angle (i_azimuth_angle),
        .i_polar_angle   (i_polar_angle),
        .i_mode          (r_mode),
        .o_valid         (w_valid[0]),
        .o_az            (w_az[0]),
        .o_pol           (w_pol[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        dvfs_cordic_stage #(
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_az    (w_az[g]),
            .i_pol   (w_pol[g]),
            .o_valid (w_valid[g+1]),
            .o_az    (w_az[g+1]),
            .o_pol   (w_pol[g+1])
        );
    end

    dvfs_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[CORDIC_STAGES]),
        .i_az      (w_az[CORDIC_STAGES]),
        .i_pol     (w_pol[CORDIC_STAGES]),
        .o_valid   (w_rnd_valid),
        .o_cos_az  (w_cos_az),
        .o_sin_az  (w_sin_az),
        .o_cos_pol (w_cos_pol),
        .o_sin_pol (w_sin_pol)
    );

    dvfs_combine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_combine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_rnd_valid),
        .i_mode    (r_mode),
        .i_cos_az  (w_cos_az),
        .i_sin_az  (w_sin_az),
        .i_cos_pol (w_cos_pol),
        .i_sin_pol (w_sin_pol),
        .o_valid   (o_done),
        .o_vec_x   (o_vec_x),
        .o_vec_y   (o_vec_y),
        .o_vec_z   (o_vec_z)
    );

endmodule

`default_nettype wire

// File: src/dvfs_prep.sv
// Angle preparation: scales both angles to Q60, applies the azimuth sense,
// and folds each into [-pi/2, pi/2]. Two register stages. Uses dvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvfs_prep
    import dvfs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic signed [FRAC_BITS+2:0]  i_azimuth_angle,
    input  wire logic signed [FRAC_BITS+2:0]  i_polar_angle,
    input  wire t_mode                        i_mode,
    output logic                              o_valid,
    output t_rot                              o_az,
    output t_rot                              o_pol
);

    localparam int SH = Q60_FB - FRAC_BITS;

    logic                    r_valid_s1;
    logic signed [Q60_W-1:0] r_az_q60;
    logic signed [Q60_W-1:0] r_pol_q60;
    logic signed [Q60_W-1:0] n_az_q60;

    logic                    r_valid_s2;
    t_rot                    r_az;
    t_rot                    r_pol;

    function automatic t_rot fold(input logic signed [Q60_W-1:0] ang);
        t_rot r;
        r.x    = CORDIC_GAIN_Q60;
        r.y    = '0;
        r.z    = ang;
        r.flip = 1'b0;
        if (ang > HALF_PI_Q60) begin
            r.z    = ang - PI_Q60;
            r.flip = 1'b1;
        end else if (ang < -HALF_PI_Q60) begin
            r.z    = ang + PI_Q60;
            r.flip = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        n_az_q60 = Q60_W'(i_azimuth_angle) <<< SH;
        if (i_mode.azimuth_clockwise) begin
            n_az_q60 = -n_az_q60;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s1 <= 1'b0;
            r_valid_s2 <= 1'b0;
        end else begin
            r_valid_s1 <= i_valid;
            r_valid_s2 <= r_valid_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_az_q60  <= n_az_q60;
        r_pol_q60 <= Q60_W'(i_polar_angle) <<< SH;
        r_az      <= fold(r_az_q60);
        r_pol     <= fold(r_pol_q60);
    end

    assign o_valid = r_valid_s2;
    assign o_az    = r_az;
    assign o_pol   = r_pol;

endmodule

`default_nettype wire

// File: src/dvfs_cordic_stage.sv
// One registered CORDIC rotation step for both the azimuth and polar rotators.
// The arctangent constant is built at elaboration. Uses dvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvfs_cordic_stage
    import dvfs_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_rot i_az,
    input  wire t_rot i_pol,
    output logic      o_valid,
    output t_rot      o_az,
    output t_rot      o_pol
);

    localparam logic signed [Q60_W-1:0] ATAN_Q60 = signed'(atan_q60(IDX));

    logic r_valid;
    t_rot r_az;
    t_rot r_pol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_az  <= cordic_step(i_az, IDX, ATAN_Q60);
        r_pol <= cordic_step(i_pol, IDX, ATAN_Q60);
    end

    assign o_valid = r_valid;
    assign o_az    = r_az;
    assign o_pol   = r_pol;

endmodule

`default_nettype wire

// File: src/dvfs_round.sv
// Undoes the half-turn fold and rounds the Q60 cosine and sine of both angles
// to FRAC_BITS fraction bits, saturated to [-1, 1]. Two stages. Uses dvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvfs_round
    import dvfs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire t_rot                        i_az,
    input  wire t_rot                        i_pol,
    output logic                             o_valid,
    output logic signed [FRAC_BITS+1:0]      o_cos_az,
    output logic signed [FRAC_BITS+1:0]      o_sin_az,
    output logic signed [FRAC_BITS+1:0]      o_cos_pol,
    output logic signed [FRAC_BITS+1:0]      o_sin_pol
);

    localparam int OUT_W = FRAC_BITS + 2;
    localparam int SH    = Q60_FB - FRAC_BITS;
    localparam logic signed [Q60_W-1:0] RND = 64'sd1 <<< (SH - 1);
    localparam logic signed [Q60_W-1:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic                    r_valid_s1;
    logic signed [Q60_W-1:0] r_ca;
    logic signed [Q60_W-1:0] r_sa;
    logic signed [Q60_W-1:0] r_cp;
    logic signed [Q60_W-1:0] r_sp;

    logic                    r_valid_s2;
    logic signed [OUT_W-1:0] r_ca_o;
    logic signed [OUT_W-1:0] r_sa_o;
    logic signed [OUT_W-1:0] r_cp_o;
    logic signed [OUT_W-1:0] r_sp_o;

    function automatic logic signed [OUT_W-1:0] rnd(input logic signed [Q60_W-1:0] v);
        logic signed [Q60_W-1:0] t;
        logic signed [OUT_W-1:0] r;
        t = (v + RND) >>> SH;
        if (t > ONE) begin
            r = OUT_W'(ONE);
        end else if (t < -ONE) begin
            r = OUT_W'(-ONE);
        end else begin
            r = t[OUT_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s1 <= 1'b0;
            r_valid_s2 <= 1'b0;
        end else begin
            r_valid_s1 <= i_valid;
            r_valid_s2 <= r_valid_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ca   <= i_az.flip  ? -i_az.x  : i_az.x;
        r_sa   <= i_az.flip  ? -i_az.y  : i_az.y;
        r_cp   <= i_pol.flip ? -i_pol.x : i_pol.x;
        r_sp   <= i_pol.flip ? -i_pol.y : i_pol.y;
        r_ca_o <= rnd(r_ca);
        r_sa_o <= rnd(r_sa);
        r_cp_o <= rnd(r_cp);
        r_sp_o <= rnd(r_sp);
    end

    assign o_valid   = r_valid_s2;
    assign o_cos_az  = r_ca_o;
    assign o_sin_az  = r_sa_o;
    assign o_cos_pol = r_cp_o;
    assign o_sin_pol = r_sp_o;

endmodule

`default_nettype wire

// File: src/dvfs_combine.sv
// Forms x, y, z from the sines and cosines: picks the polar term by mode,
// multiplies, then rounds and saturates the x and y products into the output register. Uses dvfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvfs_combine
    import dvfs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire t_mode                       i_mode,
    input  wire logic signed [FRAC_BITS+1:0] i_cos_az,
    input  wire logic signed [FRAC_BITS+1:0] i_sin_az,
    input  wire logic signed [FRAC_BITS+1:0] i_cos_pol,
    input  wire logic signed [FRAC_BITS+1:0] i_sin_pol,
    output logic                             o_valid,
    output logic signed [FRAC_BITS+1:0]      o_vec_x,
    output logic signed [FRAC_BITS+1:0]      o_vec_y,
    output logic signed [FRAC_BITS+1:0]      o_vec_z
);

    localparam int OUT_W = FRAC_BITS + 2;
    localparam int PW    = 2 * OUT_W;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;

    logic                    r_valid_s1;
    logic signed [PW-1:0]    r_px;
    logic signed [PW-1:0]    r_py;
    logic signed [OUT_W-1:0] r_z;

    logic                    r_valid_s2;
    logic signed [OUT_W-1:0] r_x_o;
    logic signed [OUT_W-1:0] r_y_o;
    logic signed [OUT_W-1:0] r_z_o;

    logic signed [OUT_W-1:0] w_scale;
    logic signed [OUT_W-1:0] w_z;

    function automatic logic signed [OUT_W-1:0] rnd(input logic signed [PW-1:0] v);
        logic signed [PW-1:0]    t;
        logic signed [OUT_W-1:0] r;
        t = (v + RND) >>> FRAC_BITS;
        if (t > ONE) begin
            r = OUT_W'(ONE);
        end else if (t < -ONE) begin
            r = OUT_W'(-ONE);
        end else begin
            r = t[OUT_W-1:0];
        end
        return r;
    endfunction

    // From the pole axis the roles of sine and cosine of the polar angle swap.
    assign w_scale = i_mode.polar_from_axis ? i_sin_pol : i_cos_pol;
    assign w_z     = i_mode.polar_from_axis ? i_cos_pol : i_sin_pol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s1 <= 1'b0;
            r_valid_s2 <= 1'b0;
        end else begin
            r_valid_s1 <= i_valid;
            r_valid_s2 <= r_valid_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px  <= PW'(w_scale) * PW'(i_cos_az);
        r_py  <= PW'(w_scale) * PW'(i_sin_az);
        r_z   <= w_z;
        r_x_o <= rnd(r_px);
        r_y_o <= rnd(r_py);
        r_z_o <= r_z;
    end

    assign o_valid = r_valid_s2;
    assign o_vec_x = r_x_o;
    assign o_vec_y = r_y_o;
    assign o_vec_z = r_z_o;

endmodule

`default_nettype wire
